// File: rtl/core/rpb_pkg.sv
package rpb_pkg;

  localparam int unsigned CFG_INDEX_BITS = 3;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_BASE      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH    = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DEST_X          = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DEST_Y          = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BLIT_WIDTH      = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BLIT_HEIGHT     = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BYTES_PER_PIXEL = 3'd6;

  localparam int unsigned BPP_BITS = 3;
  localparam logic [BPP_BITS-1:0] BPP_RESET = 3'd3;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned PIXEL_BITS = 16;

  // byte index within a word: 0..2 low pixel, 3..5 high pixel
  localparam int unsigned BYTE_IDX_BITS = 3;
  localparam logic [BYTE_IDX_BITS-1:0] BYTE_LAST_ONE = 3'd2;
  localparam logic [BYTE_IDX_BITS-1:0] BYTE_LAST_TWO = 3'd5;
  localparam logic [BYTE_IDX_BITS-1:0] BYTE_BLUE_LO  = 3'd0;
  localparam logic [BYTE_IDX_BITS-1:0] BYTE_GREEN_LO = 3'd1;
  localparam logic [BYTE_IDX_BITS-1:0] BYTE_RED_LO   = 3'd2;
  localparam logic [BYTE_IDX_BITS-1:0] BYTE_BLUE_HI  = 3'd3;
  localparam logic [BYTE_IDX_BITS-1:0] BYTE_GREEN_HI = 3'd4;
  localparam logic [BYTE_IDX_BITS-1:0] BYTE_RED_HI   = 3'd5;

  typedef struct packed {
    logic two_px;
    logic done;
  } word_ctl_t;

endpackage

// File: rtl/core/rpb_fifo.sv
module rpb_fifo #(
  parameter int unsigned WIDTH = 66,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

  logic [WIDTH-1:0]    mem_q [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0] count_q, count_d;

  assign full_o     = (count_q == CNT_FULL);
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

// File: rtl/core/rpb_front.sv
module rpb_front #(
  parameter int unsigned DIM_BITS  = 12,
  parameter int unsigned ADDR_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             restart_i,
  input  logic [ADDR_BITS-1:0]             frame_base_i,
  input  logic [DIM_BITS-1:0]              screen_width_i,
  input  logic [DIM_BITS-1:0]              dest_x_i,
  input  logic [DIM_BITS-1:0]              dest_y_i,
  input  logic [DIM_BITS-1:0]              blit_width_i,
  input  logic [DIM_BITS-1:0]              blit_height_i,
  input  logic [rpb_pkg::BPP_BITS-1:0]     bytes_per_pixel_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [rpb_pkg::WORD_BITS-1:0]    source_word_i,
  output logic                             push_o,
  output logic [ADDR_BITS-1:0]             push_addr_o,
  output logic [rpb_pkg::WORD_BITS-1:0]    push_word_o,
  output rpb_pkg::word_ctl_t               push_ctl_o,
  input  logic                             full_i
);

  localparam int unsigned CW = DIM_BITS - 1;
  localparam int unsigned PW = 2 * DIM_BITS + 2;
  localparam int unsigned SW = PW + rpb_pkg::BPP_BITS;
  localparam int unsigned EW = (ADDR_BITS > SW) ? ADDR_BITS : SW;

  logic [DIM_BITS-1:0] row_q, row_d;
  logic [CW-1:0]       col_q, col_d;

  logic [DIM_BITS:0]   w_plus;
  logic [DIM_BITS-1:0] per_row_m1;
  logic                active;
  logic                row_end;
  logic                row_last;
  logic                accept;
  logic                s1_free;
  logic                s2_free;

  logic                          s1_v_q;
  logic [rpb_pkg::WORD_BITS-1:0] s1_word_q;
  logic [DIM_BITS-1:0]           s1_row_q;
  logic [CW-1:0]                 s1_col_q;
  rpb_pkg::word_ctl_t            s1_ctl_q;

  logic                          s2_v_q;
  logic [PW-1:0]                 s2_prod_q;
  logic [rpb_pkg::WORD_BITS-1:0] s2_word_q;
  logic [CW-1:0]                 s2_col_q;
  rpb_pkg::word_ctl_t            s2_ctl_q;

  logic [DIM_BITS:0] line;
  logic [PW-1:0]     prod_d;
  logic [SW-1:0]     scaled;
  logic [EW-1:0]     col_bytes;
  logic [EW-1:0]     addr_sum;

  assign w_plus     = {1'b0, blit_width_i} + 1'b1;
  assign per_row_m1 = w_plus[DIM_BITS:1] - 1'b1;
  assign active     = (blit_width_i != '0) && (blit_height_i != '0);
  assign row_end    = ({1'b0, col_q} == per_row_m1);
  assign row_last   = (row_q == blit_height_i - 1'b1);

  assign s2_free    = !s2_v_q || !full_i;
  assign s1_free    = !s1_v_q || s2_free;
  assign in_stall_o = !s1_free;
  assign accept     = in_valid_i && s1_free;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (restart_i) begin
      row_d = '0;
      col_d = '0;
    end else if (accept && active) begin
      if (row_end) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
      if (s1_free) begin
        s1_v_q <= accept && active;
      end
      if (s2_free) begin
        s2_v_q <= s1_v_q;
      end
    end
  end

  // row start: ((dest_y + row) * screen_width + dest_x), scaled in the next stage
  assign line   = {1'b0, dest_y_i} + {1'b0, s1_row_q};
  assign prod_d = PW'(line) * PW'(screen_width_i) + PW'(dest_x_i);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_word_q       <= source_word_i;
      s1_row_q        <= row_q;
      s1_col_q        <= col_q;
      s1_ctl_q.two_px <= !(row_end && blit_width_i[0]);
      s1_ctl_q.done   <= row_end && row_last;
    end
    if (s1_v_q && s2_free) begin
      s2_prod_q <= prod_d;
      s2_word_q <= s1_word_q;
      s2_col_q  <= s1_col_q;
      s2_ctl_q  <= s1_ctl_q;
    end
  end

  assign scaled    = SW'(s2_prod_q) * SW'(bytes_per_pixel_i);
  assign col_bytes = (EW'(s2_col_q) << 2) + (EW'(s2_col_q) << 1);
  assign addr_sum  = EW'(frame_base_i) + EW'(scaled) + col_bytes;

  assign push_o      = s2_v_q && !full_i;
  assign push_addr_o = addr_sum[ADDR_BITS-1:0];
  assign push_word_o = s2_word_q;
  assign push_ctl_o  = s2_ctl_q;

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    restart_i |=> (row_q == '0 && col_q == '0))
    else $error("position not cleared on restart");

endmodule

// File: rtl/core/rpb_back.sv
module rpb_back #(
  parameter int unsigned ADDR_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  logic [ADDR_BITS-1:0]          head_addr_i,
  input  logic [rpb_pkg::WORD_BITS-1:0] head_word_i,
  input  rpb_pkg::word_ctl_t            head_ctl_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ADDR_BITS-1:0]          write_address_o,
  output logic [7:0]                    write_byte_o,
  output logic                          last_of_word_o,
  output logic                          blit_done_o
);

  logic                                cur_v_q;
  logic [ADDR_BITS-1:0]                cur_addr_q;
  logic [rpb_pkg::WORD_BITS-1:0]       cur_word_q;
  rpb_pkg::word_ctl_t                  cur_ctl_q;
  logic [rpb_pkg::BYTE_IDX_BITS-1:0]   k_q;

  logic                                out_v_q;
  logic [ADDR_BITS-1:0]                out_addr_q;
  logic [7:0]                          out_byte_q;
  logic                                out_last_q;
  logic                                out_done_q;

  logic                                out_free;
  logic                                emit;
  logic                                cur_last;
  logic                                load;
  logic [rpb_pkg::BYTE_IDX_BITS-1:0]   k_last;
  logic [rpb_pkg::PIXEL_BITS-1:0]      px;
  logic [7:0]                          byte_d;

  assign k_last   = cur_ctl_q.two_px ? rpb_pkg::BYTE_LAST_TWO : rpb_pkg::BYTE_LAST_ONE;
  assign cur_last = (k_q == k_last);
  assign out_free = !out_v_q || !out_stall_i;
  assign emit     = cur_v_q && out_free;
  assign load     = !empty_i && (!cur_v_q || (emit && cur_last));
  assign pop_o    = load;

  assign px = (k_q >= rpb_pkg::BYTE_BLUE_HI) ? cur_word_q[31:16] : cur_word_q[15:0];

  always_comb begin
    case (k_q)
      rpb_pkg::BYTE_BLUE_LO, rpb_pkg::BYTE_BLUE_HI:   byte_d = {px[4:0], 3'b000};
      rpb_pkg::BYTE_GREEN_LO, rpb_pkg::BYTE_GREEN_HI: byte_d = {px[10:6], 3'b000};
      rpb_pkg::BYTE_RED_LO, rpb_pkg::BYTE_RED_HI:     byte_d = {px[15:11], 3'b000};
      default:                                        byte_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_v_q <= 1'b0;
      k_q     <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (load) begin
        cur_v_q <= 1'b1;
        k_q     <= '0;
      end else if (emit && cur_last) begin
        cur_v_q <= 1'b0;
      end else if (emit) begin
        k_q <= k_q + 1'b1;
      end
      if (out_free) begin
        out_v_q <= cur_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_addr_q <= head_addr_i;
      cur_word_q <= head_word_i;
      cur_ctl_q  <= head_ctl_i;
    end
    if (emit) begin
      out_addr_q <= cur_addr_q + ADDR_BITS'(k_q);
      out_byte_q <= byte_d;
      out_last_q <= cur_last;
      out_done_q <= cur_last && cur_ctl_q.done;
    end
  end

  assign out_valid_o     = out_v_q;
  assign write_address_o = out_addr_q;
  assign write_byte_o    = out_byte_q;
  assign last_of_word_o  = out_last_q;
  assign blit_done_o     = out_done_q;

  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_v_q |-> (k_q <= k_last))
    else $error("byte index past end of word");

  a_done_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_done_q) |-> out_last_q)
    else $error("blit end flagged on a byte that does not end its word");

endmodule

// File: rtl/core/rgb565_pair_to_rgb888_blit.sv
// RGB565 pair to RGB888 byte blit.
// Input channel: in_valid_i / in_stall_o with source_word_i, two RGB565
// pixels per word, low half first. Output channel: out_valid_o /
// out_stall_i, one byte write per transfer: write_address_o, write_byte_o
// (blue, green, red per pixel), last_of_word_o on the final byte of a
// word and blit_done_o on the final byte of the blit. A word gives six
// bytes, or three for the closing word of an odd-width row.
// Config: cfg_we_i writes register cfg_index_i (0 frame_base ..
// 6 bytes_per_pixel) and restarts the blit at row zero; index 7 is ignored.
// A word passes front stages s1 and s2, the queue, then the current-word
// and output registers. Throughput: one output byte per cycle while the
// receiver does not stall; the back-end byte sequencer sets that rate.
// The front end computes the row address in two stages and fills a small
// word queue, so words are taken while earlier ones are still being written out.
// When the receiver stalls, the output holds and the queue fills; the
// input stalls once the queue and front stages are full.
// Reset: registers return to their defaults (base 0, screen width 1,
// x 0, y 0, width 1, height 1, three bytes per pixel), position row zero.
module rgb565_pair_to_rgb888_blit #(
  parameter int unsigned DIM_BITS    = 12,
  parameter int unsigned ADDR_BITS   = 32,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [rpb_pkg::CFG_INDEX_BITS-1:0]    cfg_index_i,
  input  logic [((ADDR_BITS > DIM_BITS) ? ADDR_BITS : DIM_BITS)-1:0] cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [rpb_pkg::WORD_BITS-1:0]         source_word_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [ADDR_BITS-1:0]                  write_address_o,
  output logic [7:0]                            write_byte_o,
  output logic                                  last_of_word_o,
  output logic                                  blit_done_o
);

  localparam int unsigned ENTRY_BITS = ADDR_BITS + rpb_pkg::WORD_BITS
                                       + $bits(rpb_pkg::word_ctl_t);

  logic [ADDR_BITS-1:0]             frame_base_q;
  logic [DIM_BITS-1:0]              screen_width_q;
  logic [DIM_BITS-1:0]              dest_x_q;
  logic [DIM_BITS-1:0]              dest_y_q;
  logic [DIM_BITS-1:0]              blit_width_q;
  logic [DIM_BITS-1:0]              blit_height_q;
  logic [rpb_pkg::BPP_BITS-1:0]     bytes_per_pixel_q;
  logic                             restart;

  logic                             push;
  logic [ADDR_BITS-1:0]             push_addr;
  logic [rpb_pkg::WORD_BITS-1:0]    push_word;
  rpb_pkg::word_ctl_t               push_ctl;
  logic                             full;
  logic                             empty;
  logic                             pop;
  logic [ENTRY_BITS-1:0]            head;
  logic [ADDR_BITS-1:0]             head_addr;
  logic [rpb_pkg::WORD_BITS-1:0]    head_word;
  rpb_pkg::word_ctl_t               head_ctl;

  assign restart = cfg_we_i && (cfg_index_i <= rpb_pkg::REG_BYTES_PER_PIXEL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_base_q      <= '0;
      screen_width_q    <= DIM_BITS'(1);
      dest_x_q          <= '0;
      dest_y_q          <= '0;
      blit_width_q      <= DIM_BITS'(1);
      blit_height_q     <= DIM_BITS'(1);
      bytes_per_pixel_q <= rpb_pkg::BPP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rpb_pkg::REG_FRAME_BASE:      frame_base_q      <= cfg_data_i[ADDR_BITS-1:0];
        rpb_pkg::REG_SCREEN_WIDTH:    screen_width_q    <= cfg_data_i[DIM_BITS-1:0];
        rpb_pkg::REG_DEST_X:          dest_x_q          <= cfg_data_i[DIM_BITS-1:0];
        rpb_pkg::REG_DEST_Y:          dest_y_q          <= cfg_data_i[DIM_BITS-1:0];
        rpb_pkg::REG_BLIT_WIDTH:      blit_width_q      <= cfg_data_i[DIM_BITS-1:0];
        rpb_pkg::REG_BLIT_HEIGHT:     blit_height_q     <= cfg_data_i[DIM_BITS-1:0];
        rpb_pkg::REG_BYTES_PER_PIXEL: bytes_per_pixel_q <= cfg_data_i[rpb_pkg::BPP_BITS-1:0];
        default: ;
      endcase
    end
  end

  rpb_front #(
    .DIM_BITS  (DIM_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .restart_i         (restart),
    .frame_base_i      (frame_base_q),
    .screen_width_i    (screen_width_q),
    .dest_x_i          (dest_x_q),
    .dest_y_i          (dest_y_q),
    .blit_width_i      (blit_width_q),
    .blit_height_i     (blit_height_q),
    .bytes_per_pixel_i (bytes_per_pixel_q),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .source_word_i     (source_word_i),
    .push_o            (push),
    .push_addr_o       (push_addr),
    .push_word_o       (push_word),
    .push_ctl_o        (push_ctl),
    .full_i            (full)
  );

  rpb_fifo #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_addr, push_word, push_ctl}),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (head),
    .empty_o     (empty)
  );

  assign {head_addr, head_word, head_ctl} = head;

  rpb_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .head_addr_i     (head_addr),
    .head_word_i     (head_word),
    .head_ctl_i      (head_ctl),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .write_address_o (write_address_o),
    .write_byte_o    (write_byte_o),
    .last_of_word_o  (last_of_word_o),
    .blit_done_o     (blit_done_o)
  );

endmodule

// File: sim/tb_rgb565_pair_to_rgb888_blit.sv
`timescale 1ns / 1ps

module tb_rgb565_pair_to_rgb888_blit;

  localparam logic [rpb_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED = 3'd7;
  localparam int DRAIN_CYCLES = 16;

  typedef struct {
    logic [31:0] addr;
    logic [7:0]  data;
    logic        word_end;
    logic        blit_end;
  } byte_write_t;

  class rgb_write_board;
    logic [31:0] base;
    logic [11:0] scr_w, dx, dy, bw, bh;
    logic [2:0]  bpp;
    logic [11:0] row_idx;
    logic [10:0] col;
    logic [31:0] next_addr;
    byte_write_t due[$];
    int errors, words, writes;

    function new();
      base = '0;
      scr_w = 12'd1;
      dx = '0;
      dy = '0;
      bw = 12'd1;
      bh = 12'd1;
      bpp = rpb_pkg::BPP_RESET;
      errors = 0;
      words = 0;
      writes = 0;
      restart();
    endfunction

    function logic [31:0] row_addr(logic [11:0] r);
      logic [31:0] line;
      line = 32'(dy) + 32'(r);
      return base + (line * 32'(scr_w) + 32'(dx)) * 32'(bpp);
    endfunction

    function void restart();
      row_idx = '0;
      col = '0;
      next_addr = row_addr(12'd0);
    endfunction

    function void write_reg(logic [rpb_pkg::CFG_INDEX_BITS-1:0] idx, logic [31:0] data);
      case (idx)
        rpb_pkg::REG_FRAME_BASE:      base = data;
        rpb_pkg::REG_SCREEN_WIDTH:    scr_w = data[11:0];
        rpb_pkg::REG_DEST_X:          dx = data[11:0];
        rpb_pkg::REG_DEST_Y:          dy = data[11:0];
        rpb_pkg::REG_BLIT_WIDTH:      bw = data[11:0];
        rpb_pkg::REG_BLIT_HEIGHT:     bh = data[11:0];
        rpb_pkg::REG_BYTES_PER_PIXEL: bpp = data[2:0];
        default:                      return;
      endcase
      restart();
    endfunction

    function void take_word(logic [31:0] w);
      logic [12:0] per_row;
      logic row_end, blit_end;
      int npix;
      logic [15:0] px;
      logic [7:0] rgb[6];
      byte_write_t wr;
      words++;
      if (bw == 0 || bh == 0) return;
      per_row = (13'(bw) + 13'd1) >> 1;
      if (row_idx >= bh || 13'(col) >= per_row) restart();
      if (col == 0) next_addr = row_addr(row_idx);
      row_end = (13'(col) == per_row - 13'd1);
      npix = (row_end && bw[0]) ? 1 : 2;
      blit_end = row_end && (row_idx == bh - 12'd1);
      for (int p = 0; p < npix; p++) begin
        px = w[16*p +: 16];
        rgb[3*p]   = 8'((px & 16'h001F) << 3);
        rgb[3*p+1] = 8'((px & 16'h07C0) >> 3);
        rgb[3*p+2] = 8'((px & 16'hF800) >> 8);
      end
      for (int k = 0; k < npix * 3; k++) begin
        wr.addr = next_addr + 32'(k);
        wr.data = rgb[k];
        wr.word_end = (k == npix * 3 - 1);
        wr.blit_end = wr.word_end && blit_end;
        due.push_back(wr);
      end
      next_addr = next_addr + 32'(npix * 3);
      if (row_end) begin
        col = '0;
        row_idx = row_idx + 12'd1;
        if (row_idx >= bh) row_idx = '0;
        next_addr = row_addr(row_idx);
      end else begin
        col = col + 11'd1;
      end
    endfunction

    function void compare_write(logic [31:0] addr, logic [7:0] data, logic word_end,
                                logic blit_end);
      byte_write_t exp_w;
      writes++;
      if (due.size() == 0) begin
        $error("byte write to %h with nothing pending", addr);
        errors++;
        return;
      end
      exp_w = due.pop_front();
      if (addr !== exp_w.addr) begin
        $error("write_address: expected %h, got %h", exp_w.addr, addr);
        errors++;
      end
      if (data !== exp_w.data) begin
        $error("write_byte: expected %h, got %h", exp_w.data, data);
        errors++;
      end
      if (word_end !== exp_w.word_end) begin
        $error("last_of_word: expected %b, got %b", exp_w.word_end, word_end);
        errors++;
      end
      if (blit_end !== exp_w.blit_end) begin
        $error("blit_done: expected %b, got %b", exp_w.blit_end, blit_end);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [rpb_pkg::CFG_INDEX_BITS-1:0] cfg_index_i = rpb_pkg::REG_FRAME_BASE;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] source_word_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] write_address_o;
  logic [7:0]  write_byte_o;
  logic        last_of_word_o;
  logic        blit_done_o;

  logic feed_steady = 1'b0;
  logic drain_steady = 1'b0;
  int   reg_writes = 0;

  rgb_write_board sb = new();

  rgb565_pair_to_rgb888_blit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .source_word_i  (source_word_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .write_address_o(write_address_o),
    .write_byte_o   (write_byte_o),
    .last_of_word_o (last_of_word_o),
    .blit_done_o    (blit_done_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.compare_write(write_address_o, write_byte_o, last_of_word_o, blit_done_o);
    end
  end

  initial begin
    int gap;
    forever begin
      gap = drain_steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(rst_ni && out_valid_o));
    end
  end

  function automatic logic [31:0] with_junk(logic [31:0] v, logic [31:0] m);
    return (32'($urandom) & ~m) | (v & m);
  endfunction

  task automatic send_word(input logic [31:0] w);
    int gap;
    gap = feed_steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    source_word_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_word(w);
  endtask

  task automatic write_reg(input logic [rpb_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    reg_writes++;
  endtask

  // hold input, wait out every pending byte, then let the pipe go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int n, rand_words, per_blit;
    rand_words = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting: width 1, only the low pixel of each word
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0000);
    settle();

    // far corner, address wrap, junk in high register bits
    write_reg(rpb_pkg::REG_FRAME_BASE, 32'hFFFF_FFF8);
    write_reg(rpb_pkg::REG_SCREEN_WIDTH, 32'hABCD_EFFF);
    write_reg(rpb_pkg::REG_DEST_X, 32'h0000_0FFF);
    write_reg(rpb_pkg::REG_DEST_Y, 32'h1234_5FFF);
    write_reg(rpb_pkg::REG_BLIT_WIDTH, 32'h0000_0004);
    write_reg(rpb_pkg::REG_BLIT_HEIGHT, 32'h0000_0002);
    write_reg(rpb_pkg::REG_BYTES_PER_PIXEL, 32'hFFFF_FFFC);
    cfg_we_i <= 1'b0;
    feed_steady = 1'b1;
    drain_steady = 1'b1;
    send_word(32'h0000_FFFF);
    send_word(32'hFFFF_0000);
    send_word(32'h0020_0020);
    send_word(32'hF81F_07C0);
    send_word(32'h07E0_F81F);
    settle();
    feed_steady = 1'b0;
    drain_steady = 1'b0;

    // odd width, two rows, wraps into a second blit
    write_reg(rpb_pkg::REG_FRAME_BASE, 32'h0);
    write_reg(rpb_pkg::REG_SCREEN_WIDTH, 32'h1);
    write_reg(rpb_pkg::REG_DEST_X, 32'h0);
    write_reg(rpb_pkg::REG_DEST_Y, 32'h0);
    write_reg(rpb_pkg::REG_BLIT_WIDTH, 32'h3);
    write_reg(rpb_pkg::REG_BLIT_HEIGHT, 32'h2);
    write_reg(rpb_pkg::REG_BYTES_PER_PIXEL, 32'h1);
    cfg_we_i <= 1'b0;
    send_word(32'hAAAA_5555);
    send_word(32'h5555_AAAA);
    send_word(32'h1234_5678);
    send_word(32'h9ABC_DEF0);
    send_word(32'hDEAD_BEEF);
    settle();

    // zero screen width and zero bytes per pixel
    write_reg(rpb_pkg::REG_SCREEN_WIDTH, 32'hFFFF_F000);
    write_reg(rpb_pkg::REG_BYTES_PER_PIXEL, 32'h0000_0008);
    cfg_we_i <= 1'b0;
    send_word($urandom);
    send_word($urandom);
    settle();
    write_reg(rpb_pkg::REG_SCREEN_WIDTH, 32'h0000_0005);
    write_reg(rpb_pkg::REG_BYTES_PER_PIXEL, 32'h0000_0007);
    cfg_we_i <= 1'b0;
    send_word($urandom);
    send_word($urandom);
    settle();

    // zero width, then zero height: words dropped
    write_reg(rpb_pkg::REG_BLIT_WIDTH, 32'h0000_1000);
    cfg_we_i <= 1'b0;
    send_word($urandom);
    send_word($urandom);
    settle();
    write_reg(rpb_pkg::REG_BLIT_WIDTH, 32'h2);
    write_reg(rpb_pkg::REG_BLIT_HEIGHT, 32'h0);
    cfg_we_i <= 1'b0;
    send_word($urandom);
    settle();

    // write to the unused index must not restart the blit
    write_reg(rpb_pkg::REG_BLIT_HEIGHT, 32'h2);
    write_reg(rpb_pkg::REG_BYTES_PER_PIXEL, 32'h3);
    cfg_we_i <= 1'b0;
    send_word($urandom);
    settle();
    write_reg(REG_UNUSED, $urandom);
    cfg_we_i <= 1'b0;
    send_word($urandom);
    settle();

    // largest window, only a few words of it
    write_reg(rpb_pkg::REG_FRAME_BASE, $urandom);
    write_reg(rpb_pkg::REG_SCREEN_WIDTH, 32'h0FFF);
    write_reg(rpb_pkg::REG_DEST_X, 32'h0FFF);
    write_reg(rpb_pkg::REG_DEST_Y, 32'h0FFF);
    write_reg(rpb_pkg::REG_BLIT_WIDTH, 32'h0FFF);
    write_reg(rpb_pkg::REG_BLIT_HEIGHT, 32'h0FFF);
    write_reg(rpb_pkg::REG_BYTES_PER_PIXEL, 32'h4);
    cfg_we_i <= 1'b0;
    repeat (3) send_word($urandom);

    while (rand_words < 210) begin
      settle();
      if ($urandom_range(0, 3) != 0) write_reg(rpb_pkg::REG_FRAME_BASE, $urandom);
      if ($urandom_range(0, 3) != 0) begin
        write_reg(rpb_pkg::REG_SCREEN_WIDTH, with_junk(($urandom_range(0, 9) == 0) ? 32'd0 :
                  32'($urandom_range(1, 4095)), 32'hFFF));
      end
      if ($urandom_range(0, 3) != 0) write_reg(rpb_pkg::REG_DEST_X, $urandom);
      if ($urandom_range(0, 3) != 0) write_reg(rpb_pkg::REG_DEST_Y, $urandom);
      if ($urandom_range(0, 9) == 0) begin
        write_reg(rpb_pkg::REG_BLIT_WIDTH, with_junk(32'($urandom_range(64, 4095)), 32'hFFF));
        write_reg(rpb_pkg::REG_BLIT_HEIGHT, with_junk(32'($urandom_range(1, 4095)), 32'hFFF));
      end else begin
        write_reg(rpb_pkg::REG_BLIT_WIDTH, with_junk(32'($urandom_range(1, 8)), 32'hFFF));
        write_reg(rpb_pkg::REG_BLIT_HEIGHT, with_junk(32'($urandom_range(1, 4)), 32'hFFF));
      end
      if ($urandom_range(0, 3) != 0) begin
        write_reg(rpb_pkg::REG_BYTES_PER_PIXEL, with_junk(($urandom_range(0, 7) == 0) ?
                  32'($urandom_range(0, 7)) : 32'($urandom_range(1, 4)), 32'h7));
      end
      cfg_we_i <= 1'b0;
      feed_steady = ($urandom_range(0, 3) == 0);
      drain_steady = ($urandom_range(0, 3) == 0);
      per_blit = ((int'(sb.bw) + 1) / 2) * int'(sb.bh);
      if (sb.bw >= 12'd64) n = $urandom_range(2, 6);
      else n = per_blit * $urandom_range(1, 2) + $urandom_range(0, per_blit - 1);
      repeat (n) send_word($urandom);
      rand_words += n;
    end

    settle();
    $display("%0d source words over %0d register writes, %0d byte writes checked",
             sb.words, reg_writes, sb.writes);
    $display("odd/even widths, wraps, zero sizes, odd strides, random stalls both sides");
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
